// ----- rtl/core/tsps_pkg.sv -----
// ----------------------------------------------------------------------------
// tsps_pkg: shared types and constants of the three-sensor steering block
// Register indexes, drive mode codes, sequencer states and fixed field widths
// used by the steering core and its arithmetic units.
// ----------------------------------------------------------------------------
package tsps_pkg;

	// Default sizes of the parameterised fields
	localparam int TICK_BITS_DEF = 16;
	localparam int DUTY_BITS_DEF = 10;

	// Fixed field widths
	localparam int CAL_W      = 4;
	localparam int SPEED_W    = 10;
	localparam int GAIN_W     = 16;
	localparam int DB_W       = 10;
	localparam int ERR_W      = 11;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Centroid scale and error limit (both 1000)
	localparam int CENTROID_SCALE = 1000;
	localparam int ERR_LIMIT      = 1000;

	// PD term: Q4.12 gains, sum of two products, then truncation to integer
	localparam int Q_FRAC      = 12;
	localparam int PD_W        = 30;
	localparam int CORR_W      = PD_W - Q_FRAC;
	localparam int DUTY_SUM_W  = 20;

	// Register reset values
	localparam logic [CAL_W-1:0]   CAL_RST   = CAL_W'(1);
	localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(700);
	localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(1827);
	localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(1008);
	localparam logic [DB_W-1:0]    DB_RST    = DB_W'(100);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL        = 3'd0,
		REG_BASE_SPEED = 3'd1,
		REG_PROP_GAIN  = 3'd2,
		REG_DERIV_GAIN = 3'd3,
		REG_DEAD_BAND  = 3'd4
	} cfg_reg_t;

	// Drive mode codes
	typedef enum logic [MODE_W-1:0] {
		MODE_FWD   = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2
	} drive_mode_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST_MUL,
		ST_DIST_WB,
		ST_SUM_MUL,
		ST_SUM_WB,
		ST_DIV,
		ST_ERR,
		ST_P_MUL,
		ST_P_WB,
		ST_D_MUL,
		ST_D_WB,
		ST_DUTY
	} seq_state_t;

	// Divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/tsps_mul.sv -----
// ----------------------------------------------------------------------------
// tsps_mul: shared signed multiplier
// One signed product per cycle, registered at the output. The sequencer
// time-shares it for the distance scaling, the centroid weighting and the
// two PD products.
// ----------------------------------------------------------------------------
module tsps_mul import tsps_pkg::*; #(
	parameter int AW = 17,
	parameter int BW = 22
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	logic signed [AW+BW-1:0] p_q;

	// Register the product
	always_ff @(posedge clk) begin
		p_q <= (AW+BW)'(a) * (AW+BW)'(b);
	end

	assign p = p_q;

endmodule

// ----- rtl/core/tsps_div.sv -----
// ----------------------------------------------------------------------------
// tsps_div: unsigned restoring divider
// One quotient bit per cycle, most significant first; done is high in the
// cycle the quotient is final.
// ----------------------------------------------------------------------------
module tsps_div import tsps_pkg::*; #(
	parameter int N  = 22,
	parameter int DV = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [N-1:0]  dividend,
	input  logic [DV-1:0] divisor,
	output div_stat_t     stat,
	output logic [N-1:0]  quotient
);

	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  q_q;
	logic [DV-1:0] rem_q;
	logic [DV-1:0] dvs_q;

	logic [DV:0]   rsh;
	logic [DV:0]   diff;
	logic          ge;

	// Trial subtraction of the shifted remainder
	always_comb begin
		rsh  = {rem_q, q_q[N-1]};
		diff = rsh - {1'b0, dvs_q};
		ge   = (rsh >= {1'b0, dvs_q});
	end

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Datapath: shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[DV-1:0] : rsh[DV-1:0];
			q_q   <= {q_q[N-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign quotient  = q_q;

endmodule

// ----- rtl/core/three_sensor_pd_steering.sv -----
// ----------------------------------------------------------------------------
// three_sensor_pd_steering: weighted-centroid PD steering controller
// Three echo lengths become distances, a centroid gives the steering error,
// the drive mode follows from the error and a PD term corrects the duty.
// A zero distance sum skips the divider, whose one-bit-per-cycle loop runs
// TICK_BITS + 6 steps; the shared multiplier forms six products: the three
// distances, the weighted centroid sum and the two PD terms.
// One word at a time: the sequencer takes the next input only once the result
// is registered, while that result may still wait on the output side.
// Reset: configuration registers take their default values, previous error clears to zero.
// ----------------------------------------------------------------------------
module three_sensor_pd_steering import tsps_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF,
	localparam int IN_W  = ((3 * TICK_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((MODE_W + DUTY_BITS + ERR_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// echo_left_ticks, echo_mid_ticks, echo_right_ticks, zero fill
	input  logic [IN_W-1:0]       s_axis_tdata,
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// drive_mode, duty, steer_error, zero fill
	output logic [OUT_W-1:0]      m_axis_tdata,
	// div_fault
	output logic                  m_axis_tuser
);

	// Widths derived from the tick width
	localparam int TW = TICK_BITS;
	localparam int K  = TW + 11;          // reciprocal shift
	localparam int QW = TW - 6;           // raw distance quotient
	localparam int DW = TW - 5;           // signed distance
	localparam int SW = DW + 2;           // signed distance sum
	localparam int NW = DW + 12;          // signed weighted numerator
	localparam int EW = NW + 1;           // unclamped error
	localparam int AW = (TW + 1 > GAIN_W + 1) ? TW + 1 : GAIN_W + 1;
	localparam int BW = TW + 6;
	localparam int PW = AW + BW;
	// ceil(17 * 2^K / 2000): exact floor(t * 17 / 2000) for every t below 2^TW
	localparam longint unsigned M_VAL = ((64'd17 << K) + 64'd1999) / 64'd2000;

	// Configuration registers
	logic [CAL_W-1:0]   cal_q;
	logic [SPEED_W-1:0] base_q;
	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  kd_q;
	logic [DB_W-1:0]    db_q;

	// Sequencer
	seq_state_t state_q, state_d;
	logic [1:0] idx_q;

	// Datapath registers
	logic [TW-1:0]              tick_q [3];
	logic signed [DW-1:0]       d_q    [3];
	logic                       fault_q;
	logic                       qneg_q;
	logic signed [ERR_W-1:0]    e_q;
	logic signed [ERR_W-1:0]    last_q;
	drive_mode_t                mode_q;
	logic signed [PD_W-1:0]     s_q;

	// Output register
	logic                       out_valid_q;
	drive_mode_t                out_mode_q;
	logic [DUTY_BITS-1:0]       out_duty_q;
	logic signed [ERR_W-1:0]    out_err_q;
	logic                       out_fault_q;

	// Shared units
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic                 div_start;
	div_stat_t            div_stat;
	logic [NW-2:0]        quot;

	// Combinational datapath
	logic [QW-1:0]            dist_raw;
	logic signed [DW-1:0]     dist_new;
	logic signed [SW-1:0]     sum_c;
	logic signed [SW-1:0]     sum_neg;
	logic [SW-2:0]            sum_mag;
	logic signed [SW-1:0]     wsum_c;
	logic signed [NW-1:0]     num_c;
	logic signed [NW-1:0]     num_neg;
	logic [NW-2:0]            num_mag;
	logic signed [NW-1:0]     q_s;
	logic signed [EW-1:0]     e_raw;
	logic signed [ERR_W-1:0]  e_clamp;
	logic signed [ERR_W-1:0]  e_nxt;
	logic signed [ERR_W:0]    e_ext;
	logic signed [ERR_W:0]    db_ext;
	logic                     dist_equal;
	drive_mode_t              mode_nxt;
	logic signed [ERR_W:0]    de_c;
	logic signed [PD_W-1:0]   s_adj;
	logic signed [CORR_W-1:0] corr;
	logic signed [CORR_W:0]   corr_sel;
	logic                     negate;
	logic signed [DUTY_SUM_W-1:0] dsum;
	logic [DUTY_BITS-1:0]     duty_nxt;
	logic                     duty_load;

	tsps_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	tsps_div #(
		.N  (NW - 1),
		.DV (SW - 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (sum_mag),
		.stat     (div_stat),
		.quotient (quot)
	);

	// Distance: scaled quotient less calibration
	always_comb begin
		dist_raw = prod[K +: QW];
		dist_new = $signed({1'b0, dist_raw}) - $signed({{(DW - CAL_W){1'b0}}, cal_q});
	end

	// Centroid operands and their magnitudes
	always_comb begin
		sum_c   = SW'(d_q[0]) + SW'(d_q[1]) + SW'(d_q[2]);
		sum_neg = -sum_c;
		sum_mag = sum_c[SW-1] ? sum_neg[SW-2:0] : sum_c[SW-2:0];
		wsum_c  = SW'(d_q[1]) + (SW'(d_q[2]) <<< 1);
		num_c   = prod[NW-1:0];
		num_neg = -num_c;
		num_mag = num_c[NW-1] ? num_neg[NW-2:0] : num_c[NW-2:0];
	end

	// Error: signed quotient less the scale, clamped; zero on a fault
	always_comb begin
		q_s   = qneg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		e_raw = EW'(q_s) - EW'(CENTROID_SCALE);
		if (e_raw > EW'(ERR_LIMIT)) begin
			e_clamp = ERR_W'(ERR_LIMIT);
		end else if (e_raw < -EW'(ERR_LIMIT)) begin
			e_clamp = -ERR_W'(ERR_LIMIT);
		end else begin
			e_clamp = e_raw[ERR_W-1:0];
		end
		e_nxt = fault_q ? '0 : e_clamp;
	end

	// Drive mode from distances and error
	always_comb begin
		e_ext      = (ERR_W + 1)'(e_nxt);
		db_ext     = $signed({2'b00, db_q});
		dist_equal = (d_q[0] == d_q[1]) && (d_q[1] == d_q[2]);
		priority if (dist_equal) begin
			mode_nxt = MODE_LEFT;
		end else if (e_ext < -db_ext) begin
			mode_nxt = MODE_LEFT;
		end else if (e_ext > db_ext) begin
			mode_nxt = MODE_RIGHT;
		end else begin
			mode_nxt = MODE_FWD;
		end
	end

	// PD correction and duty clamp
	always_comb begin
		de_c     = (ERR_W + 1)'(e_q) - (ERR_W + 1)'(last_q);
		s_adj    = s_q[PD_W-1] ? s_q + PD_W'((1 << Q_FRAC) - 1) : s_q;
		corr     = s_adj[PD_W-1:Q_FRAC];
		negate   = (mode_q == MODE_LEFT) || ((mode_q == MODE_FWD) && e_q[ERR_W-1]);
		corr_sel = negate ? -(CORR_W + 1)'(corr) : (CORR_W + 1)'(corr);
		dsum     = $signed({{(DUTY_SUM_W - SPEED_W){1'b0}}, base_q}) + DUTY_SUM_W'(corr_sel);
		if (dsum < 0) begin
			duty_nxt = '0;
		end else if (dsum > DUTY_SUM_W'((1 << DUTY_BITS) - 1)) begin
			duty_nxt = '1;
		end else begin
			duty_nxt = dsum[DUTY_BITS-1:0];
		end
		duty_load = (state_q == ST_DUTY) && (!out_valid_q || m_axis_tready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_axis_tvalid) state_d = ST_DIST_MUL;
			ST_DIST_MUL: state_d = ST_DIST_WB;
			ST_DIST_WB:  state_d = (idx_q == 2'd2) ? ST_SUM_MUL : ST_DIST_MUL;
			ST_SUM_MUL:  state_d = ST_SUM_WB;
			ST_SUM_WB:   state_d = (sum_c == '0) ? ST_ERR : ST_DIV;
			ST_DIV:      if (div_stat.done) state_d = ST_ERR;
			ST_ERR:      state_d = ST_P_MUL;
			ST_P_MUL:    state_d = ST_P_WB;
			ST_P_WB:     state_d = ST_D_MUL;
			ST_D_MUL:    state_d = ST_D_WB;
			ST_D_WB:     state_d = ST_DUTY;
			ST_DUTY:     if (duty_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands, divider start, input ready
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		div_start     = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_DIST_MUL: begin
				mul_a = $signed({{(AW - TW){1'b0}}, tick_q[0]});
				mul_b = $signed(BW'(M_VAL));
			end
			ST_SUM_MUL: begin
				mul_a = AW'(CENTROID_SCALE);
				mul_b = BW'(wsum_c);
			end
			ST_SUM_WB: begin
				div_start = (sum_c != '0);
			end
			ST_P_MUL: begin
				mul_a = $signed({{(AW - GAIN_W){1'b0}}, kp_q});
				mul_b = BW'(e_q);
			end
			ST_D_MUL: begin
				mul_a = $signed({{(AW - GAIN_W){1'b0}}, kd_q});
				mul_b = BW'(de_c);
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= CAL_RST;
			base_q <= SPEED_RST;
			kp_q   <= KP_RST;
			kd_q   <= KD_RST;
			db_q   <= DB_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAL:        cal_q  <= cfg_data[CAL_W-1:0];
				REG_BASE_SPEED: base_q <= cfg_data[SPEED_W-1:0];
				REG_PROP_GAIN:  kp_q   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: kd_q   <= cfg_data[GAIN_W-1:0];
				REG_DEAD_BAND:  db_q   <= cfg_data[DB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_DIST_WB) begin
				idx_q <= idx_q + 2'd1;
			end
			if (duty_load) begin
				last_q      <= e_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Latch the three echo lengths
		if (s_axis_tvalid && s_axis_tready) begin
			tick_q[0] <= s_axis_tdata[TW-1:0];
			tick_q[1] <= s_axis_tdata[2*TW-1:TW];
			tick_q[2] <= s_axis_tdata[3*TW-1:2*TW];
		end
		// Advance the tick and distance lines, one sensor per pass
		if (state_q == ST_DIST_WB) begin
			tick_q[0] <= tick_q[1];
			tick_q[1] <= tick_q[2];
			d_q[0]    <= d_q[1];
			d_q[1]    <= d_q[2];
			d_q[2]    <= dist_new;
		end
		// Note the fault and the quotient sign
		if (state_q == ST_SUM_WB) begin
			fault_q <= (sum_c == '0);
			qneg_q  <= num_c[NW-1] ^ sum_c[SW-1];
		end
		if (state_q == ST_ERR) begin
			e_q    <= e_nxt;
			mode_q <= mode_nxt;
		end
		// Accumulate the PD sum
		if (state_q == ST_P_WB) begin
			s_q <= prod[PD_W-1:0];
		end
		if (state_q == ST_D_WB) begin
			s_q <= s_q + prod[PD_W-1:0];
		end
		// Hold the result word
		if (duty_load) begin
			out_mode_q  <= mode_q;
			out_duty_q  <= duty_nxt;
			out_err_q   <= e_q;
			out_fault_q <= fault_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_err_q, out_duty_q, out_mode_q});
	assign m_axis_tuser  = out_fault_q;

	// The sequencer waits on the divider for as long as it runs
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide state");

	// A faulted word carries a zero error
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fault_q) |-> (out_err_q == '0))
		else $error("fault word with non-zero error");

	// The error stays within its clamp
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_err_q <= ERR_W'(ERR_LIMIT)) && (out_err_q >= -ERR_W'(ERR_LIMIT))))
		else $error("steering error outside the clamp");

	// A result word only appears from the duty state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DUTY))
		else $error("result word raised outside the duty state");

endmodule

// ----- tb/three_sensor_pd_steering_tb.sv -----
// ----------------------------------------------------------------------------
// three_sensor_pd_steering_tb: self-checking bench of the PD steering block
// Streams echo triples through the block with bursty input and a stalling
// output side, predicts every result word from a behavioural model of the
// distance, centroid, mode and PD stages, and checks each field in order.
// Register settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_sensor_pd_steering_tb;
	import tsps_pkg::*;

	localparam int TICKS    = TICK_BITS_DEF;
	localparam int IN_W     = ((3 * TICKS + 7) / 8) * 8;
	localparam int OUT_W    = ((MODE_W + DUTY_BITS_DEF + ERR_W + 7) / 8) * 8;
	localparam longint DUTY_MAX  = (longint'(1) << DUTY_BITS_DEF) - 1;
	localparam longint PD_SCALE  = longint'(1) << Q_FRAC;
	// Echo ticks to centimetres: ticks * 17 / 2000
	localparam longint SOUND_NUM = 17;
	localparam longint SOUND_DEN = 2000;
	localparam int MAX_CM        = 557;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam int HOLDOFF_AT     = 30;
	localparam int HOLDOFF_CYCLES = 800;
	localparam int SETTLE_CYCLES  = 40;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [TICKS-1:0] right;
		logic [TICKS-1:0] mid;
		logic [TICKS-1:0] left;
	} echo_set_t;

	typedef struct packed {
		drive_mode_t              mode;
		logic [DUTY_BITS_DEF-1:0] duty;
		logic signed [ERR_W-1:0]  err;
		logic                     fault;
	} steer_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tuser;

	// Shadow registers and controller state
	logic [CAL_W-1:0]        cal_cm     = CAL_RST;
	logic [SPEED_W-1:0]      base_duty  = SPEED_RST;
	logic [GAIN_W-1:0]       kp_q12     = KP_RST;
	logic [GAIN_W-1:0]       kd_q12     = KD_RST;
	logic [DB_W-1:0]         band_limit = DB_RST;
	logic signed [ERR_W-1:0] prev_err   = '0;

	echo_set_t     pending_echoes[$];
	steer_result_t expected_results[$];
	int queued_total   = 0;
	int accepted_count = 0;
	int fail_count     = 0;
	int cycle_count    = 0;

	three_sensor_pd_steering i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out the result word of one echo triple and advance the error state
	task automatic predict_steering(input echo_set_t echoes);
		longint d_l, d_m, d_r, d_sum, err, pd_sum, corr, duty_val;
		steer_result_t res;
		d_l = longint'(echoes.left) * SOUND_NUM / SOUND_DEN - longint'(cal_cm);
		d_m = longint'(echoes.mid) * SOUND_NUM / SOUND_DEN - longint'(cal_cm);
		d_r = longint'(echoes.right) * SOUND_NUM / SOUND_DEN - longint'(cal_cm);
		d_sum = d_l + d_m + d_r;
		err = 0;
		res.fault = (d_sum == 0);
		if (!res.fault) begin
			err = (CENTROID_SCALE * d_m + 2 * CENTROID_SCALE * d_r) / d_sum
				- CENTROID_SCALE;
			if (err > ERR_LIMIT) err = ERR_LIMIT;
			if (err < -ERR_LIMIT) err = -ERR_LIMIT;
		end
		// Equal distances pivot left whatever the error
		if (d_l == d_m && d_m == d_r) res.mode = MODE_LEFT;
		else if (err < -longint'(band_limit)) res.mode = MODE_LEFT;
		else if (err > longint'(band_limit)) res.mode = MODE_RIGHT;
		else res.mode = MODE_FWD;
		pd_sum = longint'(kp_q12) * err + longint'(kd_q12) * (err - longint'(prev_err));
		corr = pd_sum / PD_SCALE;
		if (res.mode == MODE_LEFT || (res.mode == MODE_FWD && err < 0)) corr = -corr;
		duty_val = longint'(base_duty) + corr;
		if (duty_val < 0) duty_val = 0;
		if (duty_val > DUTY_MAX) duty_val = DUTY_MAX;
		res.duty = duty_val[DUTY_BITS_DEF-1:0];
		res.err = err[ERR_W-1:0];
		prev_err = err[ERR_W-1:0];
		expected_results.push_back(res);
	endtask

	// Random tick count that converts to the given whole centimetres
	function automatic logic [TICKS-1:0] ticks_for_cm(input int cm);
		int lo, hi;
		lo = int'((SOUND_DEN * cm + SOUND_NUM - 1) / SOUND_NUM);
		hi = int'((SOUND_DEN * (cm + 1) + SOUND_NUM - 1) / SOUND_NUM - 1);
		if (hi > 65535) hi = 65535;
		return TICKS'($urandom_range(hi, lo));
	endfunction

	function automatic logic [TICKS-1:0] rand_ticks();
		case ($urandom_range(0, 3))
			0: return TICKS'($urandom_range(0, 600));
			1: return TICKS'($urandom_range(0, 6000));
			2: return TICKS'($urandom);
			default: return TICKS'($urandom_range(65535, 60000));
		endcase
	endfunction

	task automatic queue_echoes(input logic [TICKS-1:0] l, m, r);
		pending_echoes.push_back('{right: r, mid: m, left: l});
		queued_total++;
	endtask

	// Mostly shaped triples: equal distances, zero sums, near balance
	task automatic queue_random_echoes(input int count);
		int kind, c1, c2, c3, centre;
		logic [TICKS-1:0] t;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				queue_echoes(rand_ticks(), rand_ticks(), rand_ticks());
			end else if (kind < 55) begin
				t = rand_ticks();
				c1 = int'(longint'(t) * SOUND_NUM / SOUND_DEN);
				queue_echoes(ticks_for_cm(c1), ticks_for_cm(c1), ticks_for_cm(c1));
			end else if (kind < 65) begin
				// distances cancel out: raw sum equals three calibrations
				c1 = $urandom_range(0, cal_cm);
				c2 = $urandom_range(0, cal_cm);
				c3 = 3 * cal_cm - c1 - c2;
				case ($urandom_range(0, 2))
					0: queue_echoes(ticks_for_cm(c1), ticks_for_cm(c2), ticks_for_cm(c3));
					1: queue_echoes(ticks_for_cm(c3), ticks_for_cm(c1), ticks_for_cm(c2));
					default: queue_echoes(ticks_for_cm(c2), ticks_for_cm(c3),
						ticks_for_cm(c1));
				endcase
			end else begin
				centre = $urandom_range(0, MAX_CM);
				c1 = centre + $urandom_range(0, 20) - 10;
				c2 = centre + $urandom_range(0, 20) - 10;
				c3 = centre + $urandom_range(0, 20) - 10;
				c1 = c1 < 0 ? 0 : (c1 > MAX_CM ? MAX_CM : c1);
				c2 = c2 < 0 ? 0 : (c2 > MAX_CM ? MAX_CM : c2);
				c3 = c3 < 0 ? 0 : (c3 > MAX_CM ? MAX_CM : c3);
				queue_echoes(ticks_for_cm(c1), ticks_for_cm(c2), ticks_for_cm(c3));
			end
		end
	endtask

	// Offer one register word and hold it until taken; caller drops valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CAL:        cal_cm     = value[CAL_W-1:0];
			REG_BASE_SPEED: base_duty  = value[SPEED_W-1:0];
			REG_PROP_GAIN:  kp_q12     = value[GAIN_W-1:0];
			REG_DERIV_GAIN: kd_q12     = value[GAIN_W-1:0];
			REG_DEAD_BAND:  band_limit = value[DB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [CFG_DATA_W-1:0] cal, base, kp, kd, band);
		write_reg(REG_CAL, cal);
		write_reg(REG_BASE_SPEED, base);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_DEAD_BAND, band);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued word is taken and every result has come back
	task automatic wait_idle();
		while (accepted_count != queued_total || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: bursts of words with random gaps between them
	int burst_left = 0;
	int gap_left = 0;
	echo_set_t offered_set = '0;
	always @(posedge clk) begin
		logic offer;
		if (arst_n) begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_steering(offered_set);
				accepted_count++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_echoes.size() > 0) begin
					offered_set = pending_echoes.pop_front();
					offer = 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 60)
							: $urandom_range(0, 3);
					end else begin
						burst_left--;
					end
				end
			end
			s_axis_tvalid <= offer;
			s_axis_tdata  <= IN_W'(offered_set);
		end
	end

	// Output ready: changing stall styles, plus one long hold-off early on
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	int style_left = 0;
	int stall_style = 0;
	int pattern_count = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			pattern_count++;
			if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					stall_style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 200);
				end else begin
					style_left--;
				end
				case (stall_style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((pattern_count % 7) < 3);
				endcase
			end
		end
	end

	// Result monitor: compare each taken word with the oldest expectation
	always @(posedge clk) begin
		steer_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.mode  = drive_mode_t'(m_axis_tdata[MODE_W-1:0]);
			got.duty  = m_axis_tdata[MODE_W +: DUTY_BITS_DEF];
			got.err   = m_axis_tdata[MODE_W + DUTY_BITS_DEF +: ERR_W];
			got.fault = m_axis_tuser;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result word: mode %0d duty %0d err %0d fault %0b",
						got.mode, got.duty, got.err, got.fault);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("mismatch: expected mode %0d duty %0d err %0d fault %0b",
							want.mode, want.duty, want.err, want.fault);
						$display("          got mode %0d duty %0d err %0d fault %0b",
							got.mode, got.duty, got.err, got.fault);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: corner triples first
		queue_echoes(16'd0, 16'd0, 16'd0);
		queue_echoes(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_echoes(16'hFFFF, 16'd0, 16'd0);
		queue_echoes(16'd0, 16'd0, 16'hFFFF);
		queue_echoes(16'hFFFF, 16'd0, 16'd0);
		queue_echoes(16'd0, 16'hFFFF, 16'd0);
		queue_echoes(16'd0, 16'd0, ticks_for_cm(3));
		queue_echoes(ticks_for_cm(2), ticks_for_cm(1), ticks_for_cm(0));
		queue_echoes(16'hAAAA, 16'h5555, 16'hFFFF);
		queue_echoes(16'h5555, 16'hAAAA, 16'h0000);
		queue_echoes(16'h0001, 16'h8000, 16'h7FFF);
		queue_echoes(ticks_for_cm(101), ticks_for_cm(100), ticks_for_cm(99));
		queue_echoes(ticks_for_cm(200), ticks_for_cm(200), ticks_for_cm(250));
		queue_echoes(ticks_for_cm(90), ticks_for_cm(100), ticks_for_cm(100));
		queue_random_echoes(100);
		wait_idle();

		// No calibration, zero base, full gains, no dead band
		write_all_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		queue_echoes(16'd0, 16'd0, 16'd0);
		queue_echoes(16'd117, 16'd117, 16'd117);
		queue_echoes(16'd0, 16'd0, 16'd118);
		queue_echoes(16'hFFFF, 16'd0, 16'd0);
		queue_random_echoes(80);
		wait_idle();

		// Full calibration, top speed, zero gains, band beyond any error
		write_all_regs(16'd15, 16'd1023, 16'd0, 16'd0, 16'd1023);
		queue_random_echoes(80);
		wait_idle();

		// Bits above each register's width must be dropped
		write_all_regs(16'hFFF7, 16'hFE00, 16'd4096, 16'h8000, 16'hFC64);
		queue_random_echoes(80);
		wait_idle();

		write_all_regs(CFG_DATA_W'($urandom_range(0, 15)),
			CFG_DATA_W'($urandom_range(0, 1023)),
			CFG_DATA_W'($urandom_range(0, 8192)),
			CFG_DATA_W'($urandom_range(0, 8192)), 16'd1000);
		queue_random_echoes(70);
		wait_idle();

		repeat (2) begin
			write_all_regs(CFG_DATA_W'($urandom_range(0, 15)),
				CFG_DATA_W'($urandom_range(0, 1023)),
				CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 1023)));
			queue_random_echoes(70);
			wait_idle();
		end

		fail_count += expected_results.size();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
